>>> sv/dct_pkg.sv
`timescale 1ns / 1ps

package dct_pkg;

	// Fixed field widths of the stream items.
	localparam int FUNC_W      = 2;
	localparam int ENTITY_W    = 10;
	localparam int COMP_W      = 32;
	localparam int STATUS_W    = 2;
	localparam int DATA_OUT_W  = 32;
	localparam int COUNT_OUT_W = 11;

	// Number of entity ids that the entity field can name.
	localparam int ENTITY_SPAN = 1 << ENTITY_W;

	// Stream bus widths, padded up to whole bytes.
	localparam int S_RAW_W     = ENTITY_W + COMP_W;
	localparam int S_TDATA_W   = ((S_RAW_W + 7) / 8) * 8;
	localparam int M_RAW_W     = STATUS_W + DATA_OUT_W + COUNT_OUT_W + 1;
	localparam int M_TDATA_W   = ((M_RAW_W + 7) / 8) * 8;
	localparam int S_PAD_W     = S_TDATA_W - S_RAW_W;
	localparam int M_PAD_W     = M_TDATA_W - M_RAW_W;

	// Defaults for the top level parameters.
	localparam int MAX_KEYS_DEF   = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	// Request operations.
	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT  = 2'd0,
		FN_REMOVE  = 2'd1,
		FN_GET     = 2'd2,
		FN_DESTROY = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_DUP    = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		SQ_CLEAR = 6'b000001,
		SQ_IDLE  = 6'b000010,
		SQ_EVAL  = 6'b000100,
		SQ_GET   = 6'b001000,
		SQ_MOVE  = 6'b010000,
		SQ_DROP  = 6'b100000
	} seq_state_t;

endpackage

>>> sv/dct_mem.sv
`timescale 1ns / 1ps

module dct_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/dense_component_table_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                          Item
// request   in         s_tvalid s_tready s_tdata      tuser: func; tdata: entity, component
//                      s_tuser
// result    out        m_tvalid m_tready m_tdata      tdata: status, data, entry_count,
//                                                     was_removed
//
// A failed request or an insert passes IDLE and EVAL, a get adds GET, and a remove or
// destroy of a present entity adds MOVE and DROP, set by the registered read of the
// entity map, the dependent read of the slot memory and the single write port of the
// entity map, which a removal uses twice. After reset a clearing pass writes every entity
// map entry before the first item is taken. The result register holds an item until
// m_tready; a new item is taken while it waits; only its final cycle waits for the register.

module dense_component_table_core #(
	parameter int MAX_KEYS   = dct_pkg::MAX_KEYS_DEF,
	parameter int DATA_WIDTH = dct_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0: entity, component, zero padding.
	input  logic [dct_pkg::S_TDATA_W-1:0]  s_tdata,
	// Fields from bit 0: func.
	input  logic [dct_pkg::FUNC_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0: status, data, entry_count, was_removed, zero padding.
	output logic [dct_pkg::M_TDATA_W-1:0]  m_tdata
);

	import dct_pkg::*;

	// Entity map covers the ids that are both addressable and below MAX_KEYS.
	localparam int EK   = (MAX_KEYS < ENTITY_SPAN) ? MAX_KEYS : ENTITY_SPAN;
	localparam int EW   = $clog2(EK);
	localparam int SW   = $clog2(MAX_KEYS);
	localparam int CW   = $clog2(MAX_KEYS + 1);
	localparam int EM_W = 1 + SW;
	localparam int SM_W = EW + DATA_WIDTH;

	// Request fields.
	logic [ENTITY_W-1:0] s_entity;
	logic [COMP_W-1:0]   s_component;
	logic                accept;

	assign s_entity    = s_tdata[ENTITY_W-1:0];
	assign s_component = s_tdata[ENTITY_W +: COMP_W];

	// Sequencer and request registers.
	seq_state_t            state_q, state_d;
	func_t                 func_q;
	logic [EW-1:0]         ent_q;
	logic                  in_rng_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [CW-1:0]         count_q, count_d;
	logic [EW-1:0]         clr_idx_q;

	// Memory ports.
	logic            em_we, em_re;
	logic [EW-1:0]   em_wa, em_ra;
	logic [EM_W-1:0] em_wd, em_rd;
	logic            sm_we, sm_re;
	logic [SW-1:0]   sm_wa, sm_ra;
	logic [SM_W-1:0] sm_wd, sm_rd;

	// Result register.
	logic                  m_tvalid_q;
	status_t               st_q;
	logic [DATA_OUT_W-1:0] data_q;
	logic [COUNT_OUT_W-1:0] cnt_q;
	logic                  rm_q;

	logic                  res_ld;
	status_t               res_st;
	logic [DATA_OUT_W-1:0] res_data;
	logic                  res_rm;
	logic                  out_free;
	logic                  ins_fire;

	// Decoded view of the read data.
	logic                  ent_present;
	logic [SW-1:0]         ent_slot;
	logic                  live;
	logic [SW-1:0]         last_slot;
	logic [EW-1:0]         mover;

	// Entity map: presence mark and slot index per entity.
	dct_mem #(.DEPTH(EK), .WIDTH(EM_W), .AW(EW)) u_ent_map (
		.clk     (clk),
		.wr_en   (em_we),
		.wr_addr (em_wa),
		.wr_data (em_wd),
		.rd_en   (em_re),
		.rd_addr (em_ra),
		.rd_data (em_rd)
	);

	// Dense slot memory: owner entity and data word per slot.
	dct_mem #(.DEPTH(MAX_KEYS), .WIDTH(SM_W), .AW(SW)) u_slot_mem (
		.clk     (clk),
		.wr_en   (sm_we),
		.wr_addr (sm_wa),
		.wr_data (sm_wd),
		.rd_en   (sm_re),
		.rd_addr (sm_ra),
		.rd_data (sm_rd)
	);

	assign ent_present = em_rd[SW];
	assign ent_slot    = em_rd[SW-1:0];
	assign live        = in_rng_q && ent_present && (count_q != '0);
	assign last_slot   = SW'(count_q - 1'b1);
	assign mover       = sm_rd[DATA_WIDTH +: EW];

	assign s_tready = (state_q == SQ_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer: look up the entity, then read, move and write back slots.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		em_we    = 1'b0;
		em_wa    = ent_q;
		em_wd    = '0;
		em_re    = 1'b0;
		em_ra    = s_entity[EW-1:0];
		sm_we    = 1'b0;
		sm_wa    = ent_slot;
		sm_wd    = sm_rd;
		sm_re    = 1'b0;
		sm_ra    = ent_slot;
		res_ld   = 1'b0;
		res_st   = ST_OK;
		res_data = '0;
		res_rm   = 1'b0;
		ins_fire = 1'b0;
		case (state_q)
			SQ_CLEAR: begin
				em_we = 1'b1;
				em_wa = clr_idx_q;
				if (clr_idx_q == EW'(EK - 1)) begin
					state_d = SQ_IDLE;
				end
			end
			SQ_IDLE: begin
				em_re = accept;
				if (accept) begin
					state_d = SQ_EVAL;
				end
			end
			SQ_EVAL: begin
				case (func_q)
					FN_INSERT: begin
						if (!in_rng_q) begin
							res_st = ST_ABSENT;
						end else if (ent_present) begin
							res_st = ST_DUP;
						end else if (count_q == CW'(MAX_KEYS)) begin
							res_st = ST_FULL;
						end else begin
							ins_fire = out_free;
						end
						// Append at the end of the dense table.
						em_we   = ins_fire;
						em_wd   = {1'b1, SW'(count_q)};
						sm_we   = ins_fire;
						sm_wa   = SW'(count_q);
						sm_wd   = {ent_q, word_q};
						if (ins_fire) begin
							count_d = count_q + 1'b1;
						end
						res_ld = out_free;
						if (out_free) begin
							state_d = SQ_IDLE;
						end
					end
					FN_GET: begin
						if (live) begin
							sm_re   = 1'b1;
							state_d = SQ_GET;
						end else begin
							res_st = ST_ABSENT;
							res_ld = out_free;
							if (out_free) begin
								state_d = SQ_IDLE;
							end
						end
					end
					default: begin
						if (live) begin
							// Fetch the last live slot, which fills the hole.
							sm_re   = 1'b1;
							sm_ra   = last_slot;
							state_d = SQ_MOVE;
						end else begin
							res_st = (func_q == FN_REMOVE) ? ST_ABSENT : ST_OK;
							res_ld = out_free;
							if (out_free) begin
								state_d = SQ_IDLE;
							end
						end
					end
				endcase
			end
			SQ_GET: begin
				res_data = DATA_OUT_W'(sm_rd[DATA_WIDTH-1:0]);
				res_ld   = out_free;
				if (out_free) begin
					state_d = SQ_IDLE;
				end
			end
			SQ_MOVE: begin
				// Last entry moves into the hole; its owner points at the hole.
				sm_we   = 1'b1;
				sm_wa   = ent_slot;
				sm_wd   = sm_rd;
				em_we   = 1'b1;
				em_wa   = mover;
				em_wd   = {(mover != ent_q), ent_slot};
				state_d = SQ_DROP;
			end
			SQ_DROP: begin
				// Clear the removed entity's presence mark.
				em_we  = out_free;
				em_wd  = {1'b0, ent_slot};
				res_rm = 1'b1;
				res_ld = out_free;
				if (out_free) begin
					count_d = count_q - 1'b1;
					state_d = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SQ_CLEAR;
			count_q    <= '0;
			clr_idx_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == SQ_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (res_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func_t'(s_tuser);
			ent_q    <= s_entity[EW-1:0];
			in_rng_q <= (32'(s_entity) < MAX_KEYS);
			word_q   <= DATA_WIDTH'(s_component);
		end
		if (res_ld) begin
			st_q   <= res_st;
			data_q <= res_data;
			cnt_q  <= COUNT_OUT_W'(count_d);
			rm_q   <= res_rm;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, rm_q, cnt_q, data_q, st_q};

`ifndef SYNTHESIS
	// The live count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEYS))
		else $error("live count above table size");

	// A successful insert grows the table by exactly one entry.
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_fire |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table");

	// A slot move only happens on a non-empty table.
	a_move_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_MOVE) |-> (count_q != '0))
		else $error("slot move on an empty table");

	// A new result is only loaded from a finishing state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == SQ_EVAL || $past(state_q) == SQ_GET
			|| $past(state_q) == SQ_DROP))
		else $error("result loaded outside a finishing state");
`endif

endmodule
